@@ rtl/core/mrfe_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfe_pkg
// Shared types, codes and defaults for the matrix rotate/flip engine.
// ----------------------------------------------------------------------------
package mrfe_pkg;

    // Default sizes of the matrix stores.
    localparam int MAX_DIM_DEFAULT    = 128;
    localparam int ELEM_WIDTH_DEFAULT = 32;

    // Fixed field widths of the item and result words and of the configuration port.
    localparam int OP_W        = 2;
    localparam int CODE_W      = 3;
    localparam int INDEX_W     = 7;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int DIM_W       = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Reset value of both dimension registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 8'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Transform codes.
    localparam logic [CODE_W-1:0] TR_FLIP_V   = 3'd1;
    localparam logic [CODE_W-1:0] TR_MIRROR_H = 3'd2;
    localparam logic [CODE_W-1:0] TR_ROT_R    = 3'd3;
    localparam logic [CODE_W-1:0] TR_ROT_L    = 3'd4;
    localparam logic [CODE_W-1:0] TR_QUAD_CW  = 3'd5;
    localparam logic [CODE_W-1:0] TR_QUAD_CCW = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_ROWS = 1'd0;

    // Input word.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [CODE_W-1:0]        transform;
        logic [INDEX_W-1:0]       row;
        logic [INDEX_W-1:0]       col;
        logic signed [DATA_W-1:0] value;
    } item_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic [STATUS_W-1:0]      status;
        logic [DIM_W-1:0]         cur_rows;
        logic [DIM_W-1:0]         cur_cols;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic load_we;
        logic take_rdata;
        logic copy_step;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            index_ok;
        logic            transform_ok;
        logic            copy_last;
        logic            out_free;
    } dp_status_t;

endpackage

@@ rtl/core/mrfe_store.sv @@
// ----------------------------------------------------------------------------
// mrfe_store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module mrfe_store #(
    parameter int DEPTH = mrfe_pkg::MAX_DIM_DEFAULT * mrfe_pkg::MAX_DIM_DEFAULT,
    parameter int WIDTH = mrfe_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mrfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrfe_ctrl
// Sequencer for the engine: takes one word, steps the datapath through the
// access or the full copy, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mrfe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  mrfe_pkg::dp_status_t stat,
    output mrfe_pkg::ctrl_cmd_t  cmd
);

    import mrfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_COPY,
        S_DRAIN,
        S_DELIVER
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (stat.op)
                    OP_LOAD:
                    begin
                        cmd.load_we = stat.index_ok;
                        state_next  = S_DELIVER;
                    end
                    OP_READ:
                    begin
                        state_next = stat.index_ok ? S_READ : S_DELIVER;
                    end
                    OP_APPLY:
                    begin
                        state_next = stat.transform_ok ? S_COPY : S_DELIVER;
                    end
                    default:
                    begin
                        // Unused operation: no result.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.take_rdata = 1'b1;
                state_next     = S_DELIVER;
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last element is written at this edge.
                cmd.finish = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

@@ rtl/core/mrfe_dpath.sv @@
// ----------------------------------------------------------------------------
// mrfe_dpath
// Datapath: ping-pong element stores, dimension registers, copy counters,
// destination address mapping and the output register.
// ----------------------------------------------------------------------------
module mrfe_dpath #(
    parameter int MAX_DIM    = mrfe_pkg::MAX_DIM_DEFAULT,
    parameter int ELEM_WIDTH = mrfe_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [mrfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrfe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  mrfe_pkg::item_t                      item,
    output mrfe_pkg::result_t                    result,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    input  mrfe_pkg::ctrl_cmd_t                  cmd,
    output mrfe_pkg::dp_status_t                 stat
);

    import mrfe_pkg::*;

    localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS = $clog2(CELLS);

    // Saturate a written dimension into 1..MAX_DIM.
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_BITS-1:0] d;
        if (v == '0)
        begin
            d = DIM_BITS'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            d = DIM_BITS'(MAX_DIM);
        end
        else
        begin
            d = DIM_BITS'(v);
        end
        return d;
    endfunction

    item_t               item_reg;
    logic [DIM_BITS-1:0] rows_reg;
    logic [DIM_BITS-1:0] cols_reg;
    logic [DIM_BITS-1:0] init_rows_reg;
    logic [DIM_BITS-1:0] init_cols_reg;
    logic [DIM_BITS-1:0] init_rows_next;
    logic [DIM_BITS-1:0] init_cols_next;
    logic                live_is_b_reg;
    logic [DIM_BITS-1:0] r_reg;
    logic [DIM_BITS-1:0] c_reg;
    logic                copy_we_reg;
    logic [ADDR_BITS-1:0] copy_waddr_reg;
    logic [DATA_W-1:0]   element_reg;
    logic [STATUS_W-1:0] status_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    logic [DIM_BITS-1:0]  half_rows;
    logic [DIM_BITS-1:0]  half_cols;
    logic [DIM_BITS-1:0]  dr;
    logic [DIM_BITS-1:0]  dc;
    logic                 bot;
    logic                 rgt;
    logic [ADDR_BITS-1:0] item_addr;
    logic [ADDR_BITS-1:0] src_addr;
    logic [ADDR_BITS-1:0] dst_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [63:0]          load_wide;
    logic [63:0]          rd_wide;
    logic [ELEM_WIDTH-1:0] load_data;
    logic [ELEM_WIDTH-1:0] a_rdata;
    logic [ELEM_WIDTH-1:0] b_rdata;
    logic [ELEM_WIDTH-1:0] live_rdata;
    logic                 a_we;
    logic                 b_we;
    logic [ADDR_BITS-1:0] a_waddr;
    logic [ADDR_BITS-1:0] b_waddr;
    logic [ELEM_WIDTH-1:0] a_wdata;
    logic [ELEM_WIDTH-1:0] b_wdata;
    logic                 index_ok;
    logic                 transform_ok;
    logic                 quad_code;
    logic                 copy_last;

    // Element addresses: row times MAX_DIM plus column.
    assign item_addr = ADDR_BITS'(item_reg.row) * ADDR_BITS'(MAX_DIM)
                     + ADDR_BITS'(item_reg.col);
    assign src_addr  = ADDR_BITS'(r_reg) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(c_reg);
    assign dst_addr  = ADDR_BITS'(dr) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(dc);
    assign rd_addr   = cmd.copy_step ? src_addr : item_addr;

    // Item checks against the current dimensions.
    assign index_ok  = (32'(item_reg.row) < 32'(rows_reg)) &&
                       (32'(item_reg.col) < 32'(cols_reg));
    assign quad_code = (item_reg.transform == TR_QUAD_CW) ||
                       (item_reg.transform == TR_QUAD_CCW);
    assign transform_ok = (item_reg.transform >= TR_FLIP_V) &&
                          (item_reg.transform <= TR_QUAD_CCW) &&
                          !(quad_code && (rows_reg[0] || cols_reg[0]));
    assign copy_last = (r_reg == rows_reg - DIM_BITS'(1)) &&
                       (c_reg == cols_reg - DIM_BITS'(1));

    // Destination of the element at the copy counters.
    assign half_rows = rows_reg >> 1;
    assign half_cols = cols_reg >> 1;
    assign bot       = (r_reg >= half_rows);
    assign rgt       = (c_reg >= half_cols);

    always_comb
    begin
        dr = r_reg;
        dc = c_reg;
        case (item_reg.transform)
            TR_FLIP_V:
            begin
                dr = rows_reg - DIM_BITS'(1) - r_reg;
            end
            TR_MIRROR_H:
            begin
                dc = cols_reg - DIM_BITS'(1) - c_reg;
            end
            TR_ROT_R:
            begin
                dr = c_reg;
                dc = rows_reg - DIM_BITS'(1) - r_reg;
            end
            TR_ROT_L:
            begin
                dr = cols_reg - DIM_BITS'(1) - c_reg;
                dc = r_reg;
            end
            TR_QUAD_CW:
            begin
                if (!bot && !rgt)
                begin
                    dc = c_reg + half_cols;
                end
                else if (!bot && rgt)
                begin
                    dr = r_reg + half_rows;
                end
                else if (bot && rgt)
                begin
                    dc = c_reg - half_cols;
                end
                else
                begin
                    dr = r_reg - half_rows;
                end
            end
            TR_QUAD_CCW:
            begin
                if (!bot && !rgt)
                begin
                    dr = r_reg + half_rows;
                end
                else if (bot && !rgt)
                begin
                    dc = c_reg + half_cols;
                end
                else if (bot && rgt)
                begin
                    dr = r_reg - half_rows;
                end
                else
                begin
                    dc = c_reg - half_cols;
                end
            end
            default:
            begin
                dr = r_reg;
                dc = c_reg;
            end
        endcase
    end

    // Element width conversion on load and read.
    assign load_wide  = 64'(item_reg.value);
    assign load_data  = load_wide[ELEM_WIDTH-1:0];
    assign live_rdata = live_is_b_reg ? b_rdata : a_rdata;
    assign rd_wide    = 64'($signed(live_rdata));

    // The live store takes loads; the other store takes the copy writes.
    assign a_we    = live_is_b_reg ? copy_we_reg : cmd.load_we;
    assign a_waddr = live_is_b_reg ? copy_waddr_reg : item_addr;
    assign a_wdata = live_is_b_reg ? live_rdata : load_data;
    assign b_we    = live_is_b_reg ? cmd.load_we : copy_we_reg;
    assign b_waddr = live_is_b_reg ? item_addr : copy_waddr_reg;
    assign b_wdata = live_is_b_reg ? load_data : live_rdata;

    mrfe_store #(
        .DEPTH (CELLS),
        .WIDTH (ELEM_WIDTH)
    ) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (rd_addr),
        .rdata (a_rdata)
    );

    mrfe_store #(
        .DEPTH (CELLS),
        .WIDTH (ELEM_WIDTH)
    ) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    // Configuration values after a write.
    always_comb
    begin
        init_rows_next = init_rows_reg;
        init_cols_next = init_cols_reg;
        if (cfg_index == CFG_INIT_ROWS)
        begin
            init_rows_next = clamp_dim(cfg_data);
        end
        else
        begin
            init_cols_next = clamp_dim(cfg_data);
        end
    end

    // Control registers: dimensions, live store, copy counters, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rows_reg    <= clamp_dim(DIM_RESET);
            init_cols_reg    <= clamp_dim(DIM_RESET);
            rows_reg         <= clamp_dim(DIM_RESET);
            cols_reg         <= clamp_dim(DIM_RESET);
            live_is_b_reg    <= 1'b0;
            r_reg            <= '0;
            c_reg            <= '0;
            copy_we_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                init_rows_reg <= init_rows_next;
                init_cols_reg <= init_cols_next;
                rows_reg      <= init_rows_next;
                cols_reg      <= init_cols_next;
            end
            else if (cmd.finish)
            begin
                live_is_b_reg <= !live_is_b_reg;
                if ((item_reg.transform == TR_ROT_R) || (item_reg.transform == TR_ROT_L))
                begin
                    rows_reg <= cols_reg;
                    cols_reg <= rows_reg;
                end
            end

            // Walk the matrix in row-major order.
            if (cmd.capture)
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.copy_step)
            begin
                if (c_reg == cols_reg - DIM_BITS'(1))
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + DIM_BITS'(1);
                end
                else
                begin
                    c_reg <= c_reg + DIM_BITS'(1);
                end
            end
            copy_we_reg <= cmd.copy_step;

            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        copy_waddr_reg <= dst_addr;
        if (cmd.decode)
        begin
            element_reg <= '0;
            if (item_reg.op == OP_APPLY)
            begin
                status_reg <= transform_ok ? ST_OK : ST_REJECT;
            end
            else
            begin
                status_reg <= index_ok ? ST_OK : ST_RANGE;
            end
        end
        else if (cmd.take_rdata)
        begin
            element_reg <= rd_wide[DATA_W-1:0];
        end
        if (cmd.out_load)
        begin
            result_reg.element  <= element_reg;
            result_reg.status   <= status_reg;
            result_reg.cur_rows <= DIM_W'(rows_reg);
            result_reg.cur_cols <= DIM_W'(cols_reg);
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign stat.op           = item_reg.op;
    assign stat.index_ok     = index_ok;
    assign stat.transform_ok = transform_ok;
    assign stat.copy_last    = copy_last;
    assign stat.out_free     = !result_valid_reg || !result_stall;

endmodule

@@ rtl/core/matrix_rotate_flip_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_rotate_flip_engine
// Holds a matrix in two ping-pong stores; loads and reads single elements and
// flips, rotates or swaps quadrants of the whole matrix.
//
//   Channel   Signals                              Moves
//   item      item_valid / item_stall / item       one command word in
//   result    result_valid / result_stall / result one result word out
//   config    cfg_wen / cfg_index / cfg_data       register writes
//
// A load steps through decode and deliver and a read through decode, read and
// deliver; an apply copies all elements, set by the one read port of each
// store, which moves one element per cycle. One word is worked on at a time.
// Reset clears control state only; store contents stay undefined until loaded.
// New words are stalled from acceptance until the result enters the output
// register. A result left waiting there does not block the next word, which
// holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
module matrix_rotate_flip_engine #(
    parameter int MAX_DIM    = mrfe_pkg::MAX_DIM_DEFAULT,
    parameter int ELEM_WIDTH = mrfe_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [mrfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mrfe_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mrfe_pkg::result_t                result
);

    import mrfe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // Sequencer.
    mrfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Stores, counters and output register.
    mrfe_dpath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
